FILE: design/bis_pkg.sv
// ----------------------------------------------------------------------------
// Bilinear scaler package
// Shared widths, command and register codes, state types and the pixel word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bis_pkg;

	// Field widths of the channels and the configuration port.
	localparam int SAMPLE_W    = 16;
	localparam int SRC_DIM_W   = 10;
	localparam int DST_DIM_W   = 13;
	localparam int COUNT_W     = 12;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 13;

	// Defaults for the top-level parameters.
	localparam int DEF_MAX_WIDTH           = 512;
	localparam int DEF_MAX_HEIGHT          = 512;
	localparam int DEF_COORD_FRACTION_BITS = 16;

	// Register reset value and the destination size limit.
	localparam int DIM_RESET  = 512;
	localparam int DEST_LIMIT = 4096;

	// Depth of the queue between the front and back ends.
	localparam int QUEUE_DEPTH = 4;

	// Command codes.
	localparam logic CMD_LOAD    = 1'b0;
	localparam logic CMD_PRODUCE = 1'b1;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_SOURCE_WIDTH  = 2'd0,
		REG_SOURCE_HEIGHT = 2'd1,
		REG_DEST_WIDTH    = 2'd2,
		REG_DEST_HEIGHT   = 2'd3
	} cfg_reg_t;

	// One source pixel as held in the frame store.
	typedef struct packed {
		logic [SAMPLE_W-1:0] red;
		logic [SAMPLE_W-1:0] green;
		logic [SAMPLE_W-1:0] blue;
	} rgb_t;

	localparam int RGB_W = $bits(rgb_t);

	// Front end sequencer states.
	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL,
		F_START,
		F_DIV,
		F_POS,
		F_ADDR,
		F_PUSH
	} f_state_t;

	// Back end sequencer states.
	typedef enum logic [3:0] {
		B_IDLE,
		B_RD0,
		B_RD1,
		B_RD2,
		B_RD3,
		B_MUL0,
		B_MUL1,
		B_MUL2,
		B_OUT
	} b_state_t;

endpackage

`default_nettype wire

FILE: design/bis_if.sv
// ----------------------------------------------------------------------------
// Bilinear scaler channel interfaces
// Command channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bis_cmd_if;
	import bis_pkg::*;

	logic                valid;
	logic                ready;
	logic                command;
	logic [SAMPLE_W-1:0] red_in;
	logic [SAMPLE_W-1:0] green_in;
	logic [SAMPLE_W-1:0] blue_in;

	modport source (output valid, command, red_in, green_in, blue_in, input ready);
	modport sink   (input valid, command, red_in, green_in, blue_in, output ready);
endinterface

interface bis_result_if;
	import bis_pkg::*;

	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] red_out;
	logic [SAMPLE_W-1:0] green_out;
	logic [SAMPLE_W-1:0] blue_out;
	logic                frame_last;

	modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
	modport sink   (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

`default_nettype wire

FILE: design/bilinear_image_scaler.sv
// ----------------------------------------------------------------------------
// Bilinear image scaler
// Loads a source RGB frame and emits the bilinearly resized frame on demand.
// ----------------------------------------------------------------------------
// Usage:
//   The cmd channel carries one word per command. A load word writes its
//   pixel at the next raster position of the frame store; a produce word
//   asks for the next destination pixel, which leaves on the result channel
//   with frame_last set on the final pixel of the destination frame.
//   Sizes are set on the write port (cfg_we, cfg_index, cfg_data) while idle.
//   Loads are taken one per cycle while the queue has room and the front
//   end is idle, and give no result. After a produce word the front end
//   takes no further command until the bit-serial coordinate dividers
//   have finished and its job is queued. The back end then makes the four
//   single-port frame store reads one after another and blends them,
//   overlapped with the next division.
//   A four-entry queue lets the front end keep taking commands while the
//   receiver stalls; the result register holds its word until taken.
//   Reset clears the counters, the queue and the result register and sets
//   all sizes to 512; the frame store keeps its contents and must be loaded
//   before it is read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bilinear_image_scaler #(
	parameter int MAX_WIDTH           = bis_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT          = bis_pkg::DEF_MAX_HEIGHT,
	parameter int COORD_FRACTION_BITS = bis_pkg::DEF_COORD_FRACTION_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	bis_cmd_if.sink                              cmd,
	bis_result_if.source                         result,
	input  wire logic                            cfg_we,
	input  wire logic [bis_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [bis_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import bis_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int EW    = 2 + SRC_DIM_W + AW + RGB_W + 2 * (COORD_FRACTION_BITS + 1);

	logic          push;
	logic [EW-1:0] push_entry;
	logic          pop;
	logic [EW-1:0] head;
	logic          full;
	logic          empty;

	// Command intake, configuration and coordinate computation.
	bis_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.FRAC       (COORD_FRACTION_BITS),
		.AW         (AW),
		.EW         (EW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	// Job queue between the two ends.
	bis_fifo #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_entry),
		.pop       (pop),
		.head      (head),
		.full      (full),
		.empty     (empty)
	);

	// Frame store access and blending.
	bis_back #(
		.DEPTH (DEPTH),
		.FRAC  (COORD_FRACTION_BITS),
		.AW    (AW),
		.EW    (EW)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.result (result)
	);

endmodule

`default_nettype wire

FILE: design/bis_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bis_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port share one address.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

`default_nettype wire

FILE: design/bis_div.sv
// ----------------------------------------------------------------------------
// Bilinear scaler coordinate divider
// Restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bis_div #(
	parameter int NW = 38,
	parameter int DW = 12
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic               busy,
	output logic      [NW-1:0] quotient
);

	localparam int CNT_W = $clog2(NW + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [DW-1:0]    rem_q;
	logic [NW-1:0]    quo_q;
	logic [DW:0]      rem_sh;
	logic             fits;

	// Shift the next dividend bit into the partial remainder and try a subtract.
	assign rem_sh = {rem_q, quo_q[NW-1]};
	assign fits   = (rem_sh >= {1'b0, divisor});

	// Iteration count and busy flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(NW);
			busy_q <= 1'b1;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DW'(rem_sh - {1'b0, divisor});
			end else begin
				rem_q <= rem_sh[DW-1:0];
			end
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

FILE: design/bis_fifo.sv
// ----------------------------------------------------------------------------
// Bilinear scaler job queue
// Small register queue between the front and back ends, head read in place.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bis_fifo #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] head,
	output logic                  full,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	assign head  = mem_q[rd_ptr_q];
	assign full  = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);

endmodule

`default_nettype wire

FILE: design/bis_front.sv
// ----------------------------------------------------------------------------
// Bilinear scaler front end
// Holds configuration and counters, takes commands and turns each into a job:
// a store write for a load, a window address and fractions for a produce.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bis_front #(
	parameter int MAX_WIDTH  = 512,
	parameter int MAX_HEIGHT = 512,
	parameter int FRAC       = 16,
	parameter int AW         = 18,
	parameter int EW         = 150
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	bis_cmd_if.sink                             cmd,
	input  wire logic                           cfg_we,
	input  wire logic [bis_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [bis_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic                                push,
	output logic      [EW-1:0]                  push_entry,
	input  wire logic                           full
);

	import bis_pkg::*;

	localparam int SRC_MAX = (1 << SRC_DIM_W) - 1;
	localparam int SW_HI   = (MAX_WIDTH > SRC_MAX) ? SRC_MAX : MAX_WIDTH;
	localparam int SH_HI   = (MAX_HEIGHT > SRC_MAX) ? SRC_MAX : MAX_HEIGHT;
	localparam int FS_W    = 2 * SRC_DIM_W;
	localparam int LW      = (AW + 1 > FS_W) ? AW + 1 : FS_W;
	localparam int MW      = COUNT_W + SRC_DIM_W;
	localparam int NW      = MW + FRAC;
	localparam int CW      = SRC_DIM_W + FRAC;
	localparam int PW      = (AW > FS_W + 1) ? AW : FS_W + 1;

	// Configuration registers; the source sizes keep only their low SRC_DIM_W bits.
	logic [SRC_DIM_W-1:0] src_w_q;
	logic [SRC_DIM_W-1:0] src_h_q;
	logic [DST_DIM_W-1:0] dst_w_q;
	logic [DST_DIM_W-1:0] dst_h_q;
	logic [FS_W-1:0]      frame_size;

	// Counters.
	logic [AW-1:0]      load_ptr_q;
	logic [COUNT_W-1:0] col_q;
	logic [COUNT_W-1:0] row_q;

	f_state_t state_q;
	f_state_t state_d;

	// Clamped sizes.
	logic [SRC_DIM_W-1:0] sw_c;
	logic [SRC_DIM_W-1:0] sh_c;
	logic [DST_DIM_W-1:0] dw_c;
	logic [DST_DIM_W-1:0] dh_c;

	// Current output position.
	logic [COUNT_W-1:0] col_c;
	logic [COUNT_W-1:0] row_c;
	logic               row_end;
	logic               last;

	logic          accept;
	logic          is_load;
	logic [AW:0]   lp_inc;
	logic          lp_wrap;
	rgb_t          pixel;

	// Held produce job.
	logic [COUNT_W-1:0]   p_col_q;
	logic [COUNT_W-1:0]   p_row_q;
	logic [SRC_DIM_W-1:0] p_sw_q;
	logic [SRC_DIM_W-1:0] p_sh_q;
	logic [DST_DIM_W-1:0] p_dw_q;
	logic [DST_DIM_W-1:0] p_dh_q;
	logic                 p_last_q;
	logic [MW-1:0]        nx_q;
	logic [MW-1:0]        ny_q;
	logic [SRC_DIM_W-1:0] x0_q;
	logic [SRC_DIM_W-1:0] y0_q;
	logic [FRAC:0]        fx_q;
	logic [FRAC:0]        fy_q;
	logic [AW-1:0]        a00_q;

	// Divider connections.
	logic                 div_start;
	logic                 busy_x;
	logic                 busy_y;
	logic [NW-1:0]        quo_x;
	logic [NW-1:0]        quo_y;
	logic [DST_DIM_W-1:0] dwm1;
	logic [DST_DIM_W-1:0] dhm1;

	// Window position.
	logic [CW-1:0]        coord_x;
	logic [CW-1:0]        coord_y;
	logic [SRC_DIM_W-1:0] x0_raw;
	logic [SRC_DIM_W-1:0] y0_raw;
	logic [SRC_DIM_W-1:0] x0_c;
	logic [SRC_DIM_W-1:0] y0_c;
	logic [CW:0]          fx_w;
	logic [CW:0]          fy_w;
	logic [PW-1:0]        a00_w;

	// Clamp the configured sizes into their legal ranges.
	always_comb begin
		sw_c = (src_w_q < SRC_DIM_W'(2)) ? SRC_DIM_W'(2) :
		       (src_w_q > SRC_DIM_W'(SW_HI)) ? SRC_DIM_W'(SW_HI) : src_w_q;
		sh_c = (src_h_q < SRC_DIM_W'(2)) ? SRC_DIM_W'(2) :
		       (src_h_q > SRC_DIM_W'(SH_HI)) ? SRC_DIM_W'(SH_HI) : src_h_q;
		dw_c = (dst_w_q == '0) ? DST_DIM_W'(1) :
		       (dst_w_q > DST_DIM_W'(DEST_LIMIT)) ? DST_DIM_W'(DEST_LIMIT) : dst_w_q;
		dh_c = (dst_h_q == '0) ? DST_DIM_W'(1) :
		       (dst_h_q > DST_DIM_W'(DEST_LIMIT)) ? DST_DIM_W'(DEST_LIMIT) : dst_h_q;
	end

	// Position of the next output pixel, pulled inside a shrunken frame.
	always_comb begin
		col_c   = ({1'b0, col_q} < dw_c) ? col_q : COUNT_W'(dw_c - DST_DIM_W'(1));
		row_c   = ({1'b0, row_q} < dh_c) ? row_q : COUNT_W'(dh_c - DST_DIM_W'(1));
		row_end = ({1'b0, col_c} == dw_c - DST_DIM_W'(1));
		last    = row_end && ({1'b0, row_c} == dh_c - DST_DIM_W'(1));
	end

	// Source frame size for the load pointer wrap, following the registers at once.
	assign frame_size = FS_W'(sw_c) * FS_W'(sh_c);

	assign accept  = cmd.valid && cmd.ready;
	assign is_load = (cmd.command == CMD_LOAD);
	assign lp_inc  = {1'b0, load_ptr_q} + (AW + 1)'(1);
	assign lp_wrap = (LW'(lp_inc) >= LW'(frame_size));
	assign pixel   = '{red: cmd.red_in, green: cmd.green_in, blue: cmd.blue_in};

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_w_q <= SRC_DIM_W'(DIM_RESET);
			src_h_q <= SRC_DIM_W'(DIM_RESET);
			dst_w_q <= DST_DIM_W'(DIM_RESET);
			dst_h_q <= DST_DIM_W'(DIM_RESET);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SOURCE_WIDTH:  src_w_q <= cfg_data[SRC_DIM_W-1:0];
				REG_SOURCE_HEIGHT: src_h_q <= cfg_data[SRC_DIM_W-1:0];
				REG_DEST_WIDTH:    dst_w_q <= cfg_data;
				REG_DEST_HEIGHT:   dst_h_q <= cfg_data;
			endcase
		end
	end

	// Load pointer and output position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_ptr_q <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (accept) begin
			if (is_load) begin
				load_ptr_q <= lp_wrap ? '0 : lp_inc[AW-1:0];
			end else if (row_end) begin
				col_q <= '0;
				row_q <= last ? '0 : row_c + COUNT_W'(1);
			end else begin
				col_q <= col_c + COUNT_W'(1);
				row_q <= row_c;
			end
		end
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE:  if (accept && !is_load) state_d = F_MUL;
			F_MUL:   state_d = F_START;
			F_START: state_d = F_DIV;
			F_DIV:   if (!busy_x && !busy_y) state_d = F_POS;
			F_POS:   state_d = F_ADDR;
			F_ADDR:  state_d = F_PUSH;
			F_PUSH:  if (!full) state_d = F_IDLE;
			default: state_d = F_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		cmd.ready = 1'b0;
		push      = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				cmd.ready = !full;
				push      = accept && is_load;
			end
			F_START: div_start = 1'b1;
			F_PUSH:  push = !full;
			default: ;
		endcase
	end

	// Queue word: kind, last flag, source width, address, pixel, fractions.
	always_comb begin
		if (state_q == F_PUSH) begin
			push_entry = {CMD_PRODUCE, p_last_q, p_sw_q, a00_q, RGB_W'(0), fx_q, fy_q};
		end else begin
			push_entry = {CMD_LOAD, 1'b0, SRC_DIM_W'(0), load_ptr_q, pixel,
			              (FRAC + 1)'(0), (FRAC + 1)'(0)};
		end
	end

	// Divider operands.
	assign dwm1 = p_dw_q - DST_DIM_W'(1);
	assign dhm1 = p_dh_q - DST_DIM_W'(1);

	bis_div #(.NW(NW), .DW(COUNT_W)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({nx_q, FRAC'(0)}),
		.divisor  (dwm1[COUNT_W-1:0]),
		.busy     (busy_x),
		.quotient (quo_x)
	);

	bis_div #(.NW(NW), .DW(COUNT_W)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({ny_q, FRAC'(0)}),
		.divisor  (dhm1[COUNT_W-1:0]),
		.busy     (busy_y),
		.quotient (quo_y)
	);

	// Integer index and fraction on each axis; the last index is pulled back.
	always_comb begin
		coord_x = (p_dw_q == DST_DIM_W'(1)) ? '0 : quo_x[CW-1:0];
		coord_y = (p_dh_q == DST_DIM_W'(1)) ? '0 : quo_y[CW-1:0];
		x0_raw  = coord_x[CW-1:FRAC];
		y0_raw  = coord_y[CW-1:FRAC];
		x0_c    = (x0_raw >= p_sw_q - SRC_DIM_W'(1)) ? p_sw_q - SRC_DIM_W'(2) : x0_raw;
		y0_c    = (y0_raw >= p_sh_q - SRC_DIM_W'(1)) ? p_sh_q - SRC_DIM_W'(2) : y0_raw;
		fx_w    = {1'b0, coord_x} - {1'b0, x0_c, FRAC'(0)};
		fy_w    = {1'b0, coord_y} - {1'b0, y0_c, FRAC'(0)};
		a00_w   = PW'(y0_q) * PW'(p_sw_q) + PW'(x0_q);
	end

	// Produce job datapath.
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && accept && !is_load) begin
			p_col_q  <= col_c;
			p_row_q  <= row_c;
			p_sw_q   <= sw_c;
			p_sh_q   <= sh_c;
			p_dw_q   <= dw_c;
			p_dh_q   <= dh_c;
			p_last_q <= last;
		end
		if (state_q == F_MUL) begin
			nx_q <= MW'(p_col_q) * MW'(p_sw_q - SRC_DIM_W'(1));
			ny_q <= MW'(p_row_q) * MW'(p_sh_q - SRC_DIM_W'(1));
		end
		if (state_q == F_POS) begin
			x0_q <= x0_c;
			y0_q <= y0_c;
			fx_q <= fx_w[FRAC:0];
			fy_q <= fy_w[FRAC:0];
		end
		if (state_q == F_ADDR) begin
			a00_q <= a00_w[AW-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: design/bis_back.sv
// ----------------------------------------------------------------------------
// Bilinear scaler back end
// Owns the frame store: writes loaded pixels, reads the 2x2 window of a
// produce job one word per cycle, blends the three colors and holds the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bis_back #(
	parameter int DEPTH = 262144,
	parameter int FRAC  = 16,
	parameter int AW    = 18,
	parameter int EW    = 150
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          empty,
	input  wire logic [EW-1:0] head,
	output logic               pop,
	bis_result_if.source       result
);

	import bis_pkg::*;

	localparam int TW     = SAMPLE_W + FRAC;
	localparam int VW     = SAMPLE_W + 2 * FRAC;
	localparam int LANES  = 3;
	localparam logic [FRAC:0] ONE  = {1'b1, FRAC'(0)};
	localparam logic [VW:0]   HALF = (VW + 1)'(1) << (2 * FRAC - 1);

	// Queue word fields.
	logic                 h_kind;
	logic                 h_last;
	logic [SRC_DIM_W-1:0] h_sw;
	logic [AW-1:0]        h_addr;
	rgb_t                 h_pixel;
	logic [FRAC:0]        h_fx;
	logic [FRAC:0]        h_fy;

	assign {h_kind, h_last, h_sw, h_addr, h_pixel, h_fx, h_fy} = head;

	b_state_t state_q;
	b_state_t state_d;

	// Current produce job.
	logic                 last_q;
	logic [SRC_DIM_W-1:0] sw_q;
	logic [AW-1:0]        a00_q;
	logic [FRAC:0]        fx_q;
	logic [FRAC:0]        fy_q;

	// Frame store port.
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	rgb_t          ram_rdata;
	logic [RGB_W-1:0] ram_rdata_w;

	// Blend datapath.
	logic [FRAC:0]         wx;
	logic [FRAC:0]         wy;
	logic [SAMPLE_W-1:0]   smp    [LANES];
	logic [TW-1:0]         top_q  [LANES];
	logic [TW-1:0]         bot_q  [LANES];
	logic [VW-1:0]         v_q    [LANES];
	logic [TW+FRAC:0]      px_f   [LANES];
	logic [VW+FRAC:0]      py_f   [LANES];
	logic [VW:0]           rsum   [LANES];
	logic [SAMPLE_W-1:0]   sat    [LANES];
	logic [SAMPLE_W-1:0]   out_q  [LANES];
	logic                  out_valid_q;
	logic                  out_last_q;
	logic                  load_out;

	assign ram_rdata = rgb_t'(ram_rdata_w);

	bis_ram #(.WIDTH(RGB_W), .DEPTH(DEPTH)) u_frame_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (h_pixel),
		.rdata (ram_rdata_w)
	);

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE:  if (!empty && h_kind == CMD_PRODUCE) state_d = B_RD0;
			B_RD0:   state_d = B_RD1;
			B_RD1:   state_d = B_RD2;
			B_RD2:   state_d = B_RD3;
			B_RD3:   state_d = B_MUL0;
			B_MUL0:  state_d = B_MUL1;
			B_MUL1:  state_d = B_MUL2;
			B_MUL2:  state_d = B_OUT;
			B_OUT:   if (load_out) state_d = B_IDLE;
			default: state_d = B_IDLE;
		endcase
	end

	// Sequencer outputs: queue pop, store write and window addresses.
	always_comb begin
		pop      = 1'b0;
		ram_we   = 1'b0;
		ram_addr = a00_q;
		unique case (state_q)
			B_IDLE: begin
				pop      = !empty;
				ram_we   = !empty && h_kind == CMD_LOAD;
				ram_addr = h_addr;
			end
			B_RD1:   ram_addr = a00_q + AW'(1);
			B_RD2:   ram_addr = a00_q + AW'(sw_q);
			B_RD3:   ram_addr = a00_q + AW'(sw_q) + AW'(1);
			default: ram_addr = a00_q;
		endcase
	end

	assign load_out = (state_q == B_OUT) && (!out_valid_q || result.ready);

	// Latch a produce job as it leaves the queue.
	always_ff @(posedge clk) begin
		if (state_q == B_IDLE && !empty && h_kind == CMD_PRODUCE) begin
			last_q <= h_last;
			sw_q   <= h_sw;
			a00_q  <= h_addr;
			fx_q   <= h_fx;
			fy_q   <= h_fy;
		end
	end

	// Weights: the right-hand neighbors take fx, the left-hand ones 1 - fx.
	always_comb begin
		wx = (state_q == B_RD2 || state_q == B_MUL0) ? fx_q : ONE - fx_q;
		wy = (state_q == B_MUL2) ? fy_q : ONE - fy_q;
		smp[0] = ram_rdata.red;
		smp[1] = ram_rdata.green;
		smp[2] = ram_rdata.blue;
		for (int c = 0; c < LANES; c++) begin
			px_f[c] = (TW + FRAC + 1)'(smp[c]) * (TW + FRAC + 1)'(wx);
			py_f[c] = (VW + FRAC + 1)'((state_q == B_MUL2) ? bot_q[c] : top_q[c]) *
			          (VW + FRAC + 1)'(wy);
			rsum[c] = (VW + 1)'(v_q[c]) + HALF;
			sat[c]  = (rsum[c][VW:2*FRAC] > (VW + 1 - 2 * FRAC)'(16'hFFFF)) ?
			          16'hFFFF : rsum[c][2*FRAC+SAMPLE_W-1:2*FRAC];
		end
	end

	// Horizontal blends as window words arrive, then the vertical blend.
	always_ff @(posedge clk) begin
		for (int c = 0; c < LANES; c++) begin
			case (state_q)
				B_RD1:  top_q[c] <= px_f[c][TW-1:0];
				B_RD2:  top_q[c] <= top_q[c] + px_f[c][TW-1:0];
				B_RD3:  bot_q[c] <= px_f[c][TW-1:0];
				B_MUL0: bot_q[c] <= bot_q[c] + px_f[c][TW-1:0];
				B_MUL1: v_q[c]   <= py_f[c][VW-1:0];
				B_MUL2: v_q[c]   <= v_q[c] + py_f[c][VW-1:0];
				default: ;
			endcase
			if (load_out) begin
				out_q[c] <= sat[c];
			end
		end
		if (load_out) begin
			out_last_q <= last_q;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.red_out    = out_q[0];
	assign result.green_out  = out_q[1];
	assign result.blue_out   = out_q[2];
	assign result.frame_last = out_last_q;

endmodule

`default_nettype wire

FILE: design/bis_checker.sv
// ----------------------------------------------------------------------------
// Bilinear scaler port checker
// Watches the top-level channels for ordering and holding rules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bis_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire logic cmd_ready,
	input wire logic command,
	input wire logic res_valid,
	input wire logic res_ready,
	input wire logic frame_last
);

	import bis_pkg::*;

	logic       cmd_acc;
	logic       res_acc;
	logic [3:0] pending_q;

	assign cmd_acc = cmd_valid && cmd_ready;
	assign res_acc = res_valid && res_ready;

	// Produce words accepted but not yet answered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 4'((cmd_acc && command == CMD_PRODUCE) ? 1 : 0)
			                       - 4'(res_acc ? 1 : 0);
		end
	end

	// A result word always answers an earlier produce word.
	a_result_has_request: assert property (@(posedge clk) disable iff (!arst_n)
		res_acc |-> pending_q != 4'd0)
		else $error("result word without a pending produce word");

	// A load with nothing in flight never raises a result.
	a_load_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_acc && command == CMD_LOAD && pending_q == 4'd0) |=> !res_valid)
		else $error("result word raised by a load");

	// A stalled result stays offered.
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> res_valid)
		else $error("result word dropped while stalled");

	// The frame end flag does not change under a stall.
	a_last_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> $stable(frame_last))
		else $error("frame_last changed while stalled");

endmodule

bind bilinear_image_scaler bis_checker u_bis_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.cmd_valid  (cmd.valid),
	.cmd_ready  (cmd.ready),
	.command    (cmd.command),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.frame_last (result.frame_last)
);

`default_nettype wire

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// Bilinear image scaler testbench
// Loads source frames of many sizes, asks for destination pixels and checks
// every result word against an in-bench bilinear predictor or a typed-in
// value. The run starts with a short directed table and then moves on to
// random size phases. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module testbench;
	import bis_pkg::*;

	localparam int STORE_SIZE   = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
	localparam int FRAC         = DEF_COORD_FRACTION_BITS;
	localparam int STALL_LIMIT  = 4000;
	localparam int TARGET_ITEMS = 1600;

	typedef struct {
		rgb_t px;
		logic last;
	} pixel_t;

	// One row of the directed table: an optional destination resize, then a
	// word, with a typed-in result where one is easy to read off.
	typedef struct {
		int   resize;
		logic cmd;
		rgb_t px;
		bit   typed;
		rgb_t want;
		logic want_last;
	} step_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	bis_cmd_if    cmd_ch();
	bis_result_if res_ch();

	bilinear_image_scaler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.result    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Shadow copy of the block's state.
	rgb_t        frame_mem [0:STORE_SIZE-1];
	int unsigned src_w_reg, src_h_reg, dst_w_reg, dst_h_reg;
	int unsigned load_ptr, out_col, out_row;

	pixel_t expected_pixels[$];
	int     mismatches;
	int     idle_cycles;
	int     words_sent;
	bit     fast_send;
	bit     fast_take;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// Window base and fraction on one axis.
	function automatic void locate(input int unsigned pos, input int unsigned src,
			input int unsigned dst, output int unsigned base,
			output longint unsigned frac);
		longint unsigned coord;
		longint unsigned i0;
		coord = 0;
		if (dst > 1)
			coord = ((longint'(pos) * longint'(src - 1)) << FRAC) / longint'(dst - 1);
		i0 = coord >> FRAC;
		if (i0 >= src - 1) i0 = src - 2;
		base = int'(i0);
		frac = coord - (i0 << FRAC);
	endfunction

	function automatic logic [15:0] mix(logic [15:0] c00, logic [15:0] c10, logic [15:0] c01,
			logic [15:0] c11, longint unsigned fx, longint unsigned fy);
		longint unsigned one, top, bot, v, r;
		one = longint'(1) << FRAC;
		top = c00 * (one - fx) + c10 * fx;
		bot = c01 * (one - fx) + c11 * fx;
		v   = top * (one - fy) + bot * fy;
		r   = (v + (longint'(1) << (2 * FRAC - 1))) >> (2 * FRAC);
		return (r > 65535) ? 16'hFFFF : r[15:0];
	endfunction

	// Advances the shadow state by one word and returns the pixel it makes.
	function automatic bit scale_step(logic c, rgb_t px, output pixel_t res);
		int unsigned sw, sh, dw, dh, col, row, x0, y0, a00, a10, a01, a11;
		longint unsigned fx, fy;
		bit row_end, last;
		sw = clip(src_w_reg, 2, DEF_MAX_WIDTH);
		sh = clip(src_h_reg, 2, DEF_MAX_HEIGHT);
		dw = clip(dst_w_reg, 1, DEST_LIMIT);
		dh = clip(dst_h_reg, 1, DEST_LIMIT);
		if (c == CMD_LOAD) begin
			frame_mem[load_ptr] = px;
			load_ptr++;
			if (load_ptr >= sw * sh || load_ptr >= STORE_SIZE) load_ptr = 0;
			return 0;
		end
		col = (out_col < dw) ? out_col : dw - 1;
		row = (out_row < dh) ? out_row : dh - 1;
		row_end = (col == dw - 1);
		last = row_end && (row == dh - 1);
		locate(col, sw, dw, x0, fx);
		locate(row, sh, dh, y0, fy);
		a00 = y0 * sw + x0;
		a10 = a00 + 1;
		a01 = a00 + sw;
		a11 = a01 + 1;
		res.px.red   = mix(frame_mem[a00].red, frame_mem[a10].red,
			frame_mem[a01].red, frame_mem[a11].red, fx, fy);
		res.px.green = mix(frame_mem[a00].green, frame_mem[a10].green,
			frame_mem[a01].green, frame_mem[a11].green, fx, fy);
		res.px.blue  = mix(frame_mem[a00].blue, frame_mem[a10].blue,
			frame_mem[a01].blue, frame_mem[a11].blue, fx, fy);
		res.last = last;
		if (row_end) begin
			out_col = 0;
			out_row = last ? 0 : ((row + 1) & 12'hFFF);
		end else begin
			out_col = (col + 1) & 12'hFFF;
			out_row = row & 12'hFFF;
		end
		return 1;
	endfunction

	// Sends one word, then records the expected pixel at acceptance.
	task automatic send_word(logic c, rgb_t px, bit typed = 0, rgb_t want = '0,
			logic want_last = 1'b0);
		int gap;
		pixel_t res;
		gap = fast_send ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid    <= 1'b1;
		cmd_ch.command  <= c;
		cmd_ch.red_in   <= px.red;
		cmd_ch.green_in <= px.green;
		cmd_ch.blue_in  <= px.blue;
		do @(posedge clk); while (!cmd_ch.ready);
		words_sent++;
		if (scale_step(c, px, res)) begin
			if (typed) begin
				res.px   = want;
				res.last = want_last;
			end
			expected_pixels.push_back(res);
		end
	endtask

	// Waits until every expected pixel has come and the block has settled.
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Writes one register; the write enable drops for a cycle after each write.
	task automatic set_size(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= r;
		cfg_data  <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (r)
			REG_SOURCE_WIDTH:  src_w_reg = d[SRC_DIM_W-1:0];
			REG_SOURCE_HEIGHT: src_h_reg = d[SRC_DIM_W-1:0];
			REG_DEST_WIDTH:    dst_w_reg = d[DST_DIM_W-1:0];
			default:           dst_h_reg = d[DST_DIM_W-1:0];
		endcase
	endtask

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic rgb_t rand_pixel();
		rgb_t p;
		p.red   = rand_sample();
		p.green = rand_sample();
		p.blue  = rand_sample();
		return p;
	endfunction

	// Realigns the load pointer to the frame start, then loads a whole frame,
	// so that no window ever touches an entry that was never written.
	task automatic fill_frame();
		int unsigned n;
		while (load_ptr != 0) send_word(CMD_LOAD, rand_pixel());
		n = clip(src_w_reg, 2, DEF_MAX_WIDTH) * clip(src_h_reg, 2, DEF_MAX_HEIGHT);
		repeat (n) send_word(CMD_LOAD, rand_pixel());
	endtask

	// Mostly produce words, with some reloads mixed in.
	task automatic mixed_run(int n);
		repeat (n) begin
			if ($urandom_range(0, 6) == 0) send_word(CMD_LOAD, rand_pixel());
			else send_word(CMD_PRODUCE, rand_pixel());
		end
	endtask

	// Result receiver with random stalls.
	initial begin
		int w;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			w = fast_take ? 0 : $urandom_range(0, 14);
			if (w > 0) begin
				res_ch.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!res_ch.valid);
		end
	end

	// Compares each taken result word with the oldest expectation.
	always @(posedge clk) begin
		pixel_t e;
		if (res_ch.valid && res_ch.ready) begin
			if (expected_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result word: %h %h %h last %b", res_ch.red_out,
						res_ch.green_out, res_ch.blue_out, res_ch.frame_last);
			end else begin
				e = expected_pixels.pop_front();
				if (res_ch.red_out !== e.px.red || res_ch.green_out !== e.px.green ||
						res_ch.blue_out !== e.px.blue || res_ch.frame_last !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %h %h %h last %b, got %h %h %h last %b",
							e.px.red, e.px.green, e.px.blue, e.last, res_ch.red_out,
							res_ch.green_out, res_ch.blue_out, res_ch.frame_last);
				end
			end
		end
	end

	// Watchdog on cycles with no word moving on either channel.
	always @(posedge clk) begin
		if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Directed table: a 2x2 source scaled to 2x2 gives back the corners,
	// including the wrap to the next frame; then a 3x3 blend.
	step_t steps[] = '{
		'{0, CMD_LOAD,    '{16'h0000, 16'hFFFF, 16'h1234}, 0, '0, 1'b0},
		'{0, CMD_LOAD,    '{16'hFFFF, 16'h0000, 16'h8000}, 0, '0, 1'b0},
		'{0, CMD_LOAD,    '{16'h0001, 16'hFFFE, 16'h00FF}, 0, '0, 1'b0},
		'{0, CMD_LOAD,    '{16'h8000, 16'h7FFF, 16'hFF00}, 0, '0, 1'b0},
		'{0, CMD_PRODUCE, '0, 1, '{16'h0000, 16'hFFFF, 16'h1234}, 1'b0},
		'{0, CMD_PRODUCE, '0, 1, '{16'hFFFF, 16'h0000, 16'h8000}, 1'b0},
		'{0, CMD_PRODUCE, '0, 1, '{16'h0001, 16'hFFFE, 16'h00FF}, 1'b0},
		'{0, CMD_PRODUCE, '0, 1, '{16'h8000, 16'h7FFF, 16'hFF00}, 1'b1},
		'{0, CMD_PRODUCE, '1, 1, '{16'h0000, 16'hFFFF, 16'h1234}, 1'b0},
		'{0, CMD_PRODUCE, '1, 1, '{16'hFFFF, 16'h0000, 16'h8000}, 1'b0},
		'{0, CMD_PRODUCE, '1, 1, '{16'h0001, 16'hFFFE, 16'h00FF}, 1'b0},
		'{0, CMD_PRODUCE, '1, 1, '{16'h8000, 16'h7FFF, 16'hFF00}, 1'b1},
		'{3, CMD_PRODUCE, '0, 0, '0, 1'b0},
		'{0, CMD_PRODUCE, '0, 0, '0, 1'b0},
		'{0, CMD_PRODUCE, '0, 0, '0, 1'b0},
		'{0, CMD_PRODUCE, '0, 0, '0, 1'b0},
		'{0, CMD_PRODUCE, '0, 0, '0, 1'b0},
		'{0, CMD_PRODUCE, '0, 0, '0, 1'b0},
		'{0, CMD_PRODUCE, '0, 0, '0, 1'b0},
		'{0, CMD_PRODUCE, '0, 0, '0, 1'b0},
		'{0, CMD_PRODUCE, '0, 0, '1, 1'b1}
	};

	// Main sequence.
	initial begin
		mismatches  = 0;
		idle_cycles = 0;
		words_sent  = 0;
		fast_send   = 0;
		fast_take   = 0;
		src_w_reg = DIM_RESET;
		src_h_reg = DIM_RESET;
		dst_w_reg = DIM_RESET;
		dst_h_reg = DIM_RESET;
		load_ptr = 0;
		out_col  = 0;
		out_row  = 0;
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = '0;
		cfg_data        = '0;
		cmd_ch.valid    = 1'b0;
		cmd_ch.command  = CMD_LOAD;
		cmd_ch.red_in   = '0;
		cmd_ch.green_in = '0;
		cmd_ch.blue_in  = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_size(REG_SOURCE_WIDTH, 2);
		set_size(REG_SOURCE_HEIGHT, 2);
		set_size(REG_DEST_WIDTH, 2);
		set_size(REG_DEST_HEIGHT, 2);
		foreach (steps[i]) begin
			if (steps[i].resize != 0) begin
				drain();
				set_size(REG_DEST_WIDTH, CFG_DATA_W'(steps[i].resize));
				set_size(REG_DEST_HEIGHT, CFG_DATA_W'(steps[i].resize));
			end
			send_word(steps[i].cmd, steps[i].px, steps[i].typed, steps[i].want,
				steps[i].want_last);
		end
		drain();

		// Size extremes, written out of range so that masking and clamping
		// apply: a tall 2-column source to a 1-column destination.
		set_size(REG_SOURCE_WIDTH, 0);
		set_size(REG_SOURCE_HEIGHT, 13'h1FFF);
		set_size(REG_DEST_WIDTH, 0);
		set_size(REG_DEST_HEIGHT, 13'h1FFF);
		fill_frame();
		mixed_run(25);
		drain();

		// A small source whose width is written above its field, scaled to the
		// widest destination.
		set_size(REG_SOURCE_WIDTH, 13'h1005);
		set_size(REG_SOURCE_HEIGHT, 2);
		set_size(REG_DEST_WIDTH, DEST_LIMIT);
		set_size(REG_DEST_HEIGHT, 1);
		fill_frame();
		mixed_run(25);
		drain();

		// Random small sizes; the output counters carry over between phases.
		while (words_sent < TARGET_ITEMS) begin
			fast_send = ($urandom_range(0, 3) == 0);
			fast_take = ($urandom_range(0, 3) == 0);
			set_size(REG_SOURCE_WIDTH, CFG_DATA_W'($urandom_range(2, 8)));
			set_size(REG_SOURCE_HEIGHT, CFG_DATA_W'($urandom_range(2, 8)));
			set_size(REG_DEST_WIDTH, CFG_DATA_W'($urandom_range(1, 12)));
			set_size(REG_DEST_HEIGHT, CFG_DATA_W'($urandom_range(1, 12)));
			fill_frame();
			mixed_run($urandom_range(20, 80));
			drain();
		end

		if (mismatches == 0 && expected_pixels.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire

FILE: filelist.f
design/bis_pkg.sv
design/bis_if.sv
design/bis_ram.sv
design/bis_div.sv
design/bis_fifo.sv
design/bis_front.sv
design/bis_back.sv
design/bilinear_image_scaler.sv
design/bis_checker.sv
verif/testbench.sv
